### src/bic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bic_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_POLES   = 7;
	localparam int NUM_BQ      = 3;
	localparam int DATA_W      = 32;
	localparam int ACC_W       = 50;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int POLE_W      = 3;
	localparam int SEC_W       = $clog2(NUM_BQ + 1);
	localparam int BQ_IDX_W    = (NUM_BQ > 1) ? $clog2(NUM_BQ) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_LOWPASS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POLES   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MID     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FIRST   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_BQ0     = CFG_IDX_W'(4);

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic                         lowpass;
		logic [POLE_W-1:0]            poles;
		data_t                        mid;
		logic [CFG_W-1:0]             first;
		logic [NUM_BQ-1:0][CFG_W-1:0] bq;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_FB2,
		ST_SUB,
		ST_GAIN,
		ST_WB,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_FB2,
		OP_SUB,
		OP_GAIN,
		OP_WB
	} op_t;

	typedef struct packed {
		logic             load;
		op_t              op;
		logic [SEC_W-1:0] sec;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

### src/bic_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface bic_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [bic_pkg::SAMPLE_BITS-1:0]   sample_in;
	logic                                     trace_start;

	modport source (output valid, output sample_in, output trace_start, input ready);
	modport sink (input valid, input sample_in, input trace_start, output ready);
endinterface

interface bic_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [bic_pkg::SAMPLE_BITS-1:0]   sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### src/bic_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bic_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bic_pkg::CFG_W-1:0]     cfg_data,
	output bic_pkg::cfg_t                      cfg
);
	import bic_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowpass <= 1'b1;
			cfg_q.poles   <= POLE_W'(2);
			cfg_q.mid     <= '0;
			cfg_q.first   <= '0;
			cfg_q.bq      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOWPASS: cfg_q.lowpass <= cfg_data[0];
				REG_POLES:   cfg_q.poles   <= cfg_data[POLE_W-1:0];
				REG_MID:     cfg_q.mid     <= cfg_data[DATA_W-1:0];
				REG_FIRST:   cfg_q.first   <= cfg_data;
				default: begin
					for (int j = 0; j < NUM_BQ; j++) begin
						if (cfg_index == CFG_IDX_W'(int'(REG_BQ0) + j)) begin
							cfg_q.bq[j] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/bic_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bic_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bic_pkg::POLE_W-1:0] poles,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire bic_pkg::status_t           status,
	output bic_pkg::cmd_t                   cmd
);
	import bic_pkg::*;

	localparam int BQ_CAP = ((MAX_POLES / 2) < NUM_BQ) ? (MAX_POLES / 2) : NUM_BQ;

	state_t           state_q, state_d;
	logic [SEC_W-1:0] sec_q, sec_d;
	logic [SEC_W-1:0] nbq;
	logic [POLE_W-1:0] half;

	always_comb begin
		half = poles >> 1;
		if (int'(half) > BQ_CAP) begin
			nbq = SEC_W'(BQ_CAP);
		end else begin
			nbq = SEC_W'(half);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= '0;
		end else begin
			state_q <= state_d;
			sec_q   <= sec_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sec_d   = sec_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (poles[0]) begin
						state_d = ST_INIT;
						sec_d   = '0;
					end else if (nbq != '0) begin
						state_d = ST_INIT;
						sec_d   = SEC_W'(1);
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_INIT: state_d = (sec_q == '0) ? ST_SUB : ST_FB2;
			ST_FB2:  state_d = ST_SUB;
			ST_SUB:  state_d = ST_GAIN;
			ST_GAIN: state_d = ST_WB;
			ST_WB: begin
				if (sec_q < nbq) begin
					state_d = ST_INIT;
					sec_d   = sec_q + SEC_W'(1);
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.sec      = sec_q;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_INIT: cmd.op = OP_INIT;
			ST_FB2:  cmd.op = OP_FB2;
			ST_SUB:  cmd.op = OP_SUB;
			ST_GAIN: cmd.op = OP_GAIN;
			ST_WB:   cmd.op = OP_WB;
			ST_OUT:  cmd.out_load = !status.out_busy;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

### src/bic_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bic_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire bic_pkg::cfg_t                          cfg,
	input  wire bic_pkg::cmd_t                          cmd,
	input  wire logic signed [bic_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire logic                                   trace_start,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic signed [bic_pkg::SAMPLE_BITS-1:0]      sample_out,
	output bic_pkg::status_t                            status
);
	import bic_pkg::*;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam prod_t HALF16  = prod_t'(1) <<< 15;
	localparam prod_t HALF30  = prod_t'(1) <<< 29;
	localparam prod_t D_MAX   = prod_t'({1'b0, {(DATA_W-1){1'b1}}});
	localparam prod_t D_MIN   = -D_MAX - prod_t'(1);
	localparam data_t S_MAX   = data_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam data_t S_MIN   = -S_MAX - data_t'(1);

	function automatic data_t sat_data(prod_t v);
		if (v > D_MAX) begin
			return data_t'(D_MAX);
		end else if (v < D_MIN) begin
			return data_t'(D_MIN);
		end
		return data_t'(v);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(data_t v);
		if (v > S_MAX) begin
			return SAMPLE_BITS'(S_MAX);
		end else if (v < S_MIN) begin
			return SAMPLE_BITS'(S_MIN);
		end
		return SAMPLE_BITS'(v);
	endfunction

	data_t v_q;
	acc_t  acc_q;
	prod_t prod_q;
	data_t f_x1_q, f_y1_q;
	data_t bx1_q [NUM_BQ];
	data_t bx2_q [NUM_BQ];
	data_t by1_q [NUM_BQ];
	data_t by2_q [NUM_BQ];
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	logic                is_first;
	logic [BQ_IDX_W-1:0] bidx;
	data_t               x1, x2, y1, y2, fb, gain;
	logic [CFG_W-1:0]    coef;
	acc_t                vx, x1t, x2t, init_sum, r16;
	prod_t               r16_full, r30_full;
	data_t               mul_a, mul_b, y_new;
	logic                mul_en;

	always_comb begin
		is_first = (cmd.sec == '0);
		bidx     = is_first ? '0 : BQ_IDX_W'(cmd.sec - SEC_W'(1));
		if (is_first) begin
			x1   = f_x1_q;
			x2   = '0;
			y1   = f_y1_q;
			y2   = '0;
			coef = cfg.first;
		end else begin
			x1   = bx1_q[bidx];
			x2   = bx2_q[bidx];
			y1   = by1_q[bidx];
			y2   = by2_q[bidx];
			coef = cfg.bq[bidx];
		end
		gain = coef[CFG_W-1:DATA_W];
		fb   = coef[DATA_W-1:0];

		vx  = ACC_W'(v_q);
		x1t = is_first ? ACC_W'(x1) : (ACC_W'(x1) <<< 1);
		x2t = ACC_W'(x2);
		init_sum = cfg.lowpass ? (vx + x1t + x2t) : (vx - x1t + x2t);

		r16_full = (prod_q + HALF16) >>> 16;
		r16      = ACC_W'(r16_full);
		r30_full = (prod_q + HALF30) >>> 30;
		y_new    = sat_data(r30_full);

		mul_en = 1'b0;
		mul_a  = fb;
		mul_b  = y2;
		unique case (cmd.op)
			OP_INIT: begin
				mul_en = 1'b1;
				mul_a  = is_first ? fb : cfg.mid;
				mul_b  = y1;
			end
			OP_FB2: begin
				mul_en = 1'b1;
			end
			OP_GAIN: begin
				mul_en = 1'b1;
				mul_a  = gain;
				mul_b  = sat_data(PROD_W'(acc_q));
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= DATA_W'(sample_in);
		end else if (cmd.op == OP_WB) begin
			v_q <= y_new;
		end
		if (cmd.op == OP_INIT) begin
			acc_q <= init_sum;
		end else if (cmd.op == OP_FB2 || cmd.op == OP_SUB) begin
			acc_q <= acc_q - r16;
		end
		if (mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.out_load) begin
			out_q <= sat_sample(v_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_x1_q <= '0;
			f_y1_q <= '0;
			for (int j = 0; j < NUM_BQ; j++) begin
				bx1_q[j] <= '0;
				bx2_q[j] <= '0;
				by1_q[j] <= '0;
				by2_q[j] <= '0;
			end
		end else if (cmd.load && trace_start) begin
			f_x1_q <= '0;
			f_y1_q <= '0;
			for (int j = 0; j < NUM_BQ; j++) begin
				bx1_q[j] <= '0;
				bx2_q[j] <= '0;
				by1_q[j] <= '0;
				by2_q[j] <= '0;
			end
		end else if (cmd.op == OP_WB) begin
			if (is_first) begin
				f_x1_q <= v_q;
				f_y1_q <= y_new;
			end else begin
				bx2_q[bidx] <= bx1_q[bidx];
				bx1_q[bidx] <= v_q;
				by2_q[bidx] <= by1_q[bidx];
				by1_q[bidx] <= y_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample_out      = out_q;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

`default_nettype wire

### src/butterworth_iir_cascade.sv
// Each item passes through the first-order section when the pole count is odd,
// then through each biquad in use (up to 3), all on the single shared 32x32
// multiplier stepping through every section in turn. A new item is accepted
// only once the previous result has been loaded into the output register.
// Reset: configuration returns to its defaults, all history clears, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module butterworth_iir_cascade (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bic_pkg::CFG_W-1:0]     cfg_data,
	bic_in_if.sink                             sample_ch,
	bic_out_if.source                          result_ch
);
	import bic_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	bic_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.poles    (cfg.poles),
		.in_valid (sample_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bic_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sample_in   (sample_ch.sample_in),
		.trace_start (sample_ch.trace_start),
		.out_ready   (result_ch.ready),
		.out_valid   (result_ch.valid),
		.sample_out  (result_ch.sample_out),
		.status      (status)
	);

	assign sample_ch.ready = in_ready;

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
		else $error("item accepted while previous item in flight");

	a_sec_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sec <= SEC_W'(NUM_BQ))
		else $error("section index out of range");

	a_fb2_biquad_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FB2) |-> (cmd.sec != '0))
		else $error("y2 feedback step on first-order section");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(result_ch.valid && !result_ch.ready))
		else $error("result register overwritten while pending");

endmodule

`default_nettype wire

### tb/butterworth_iir_cascade_test.sv
`timescale 1ns / 1ps

module butterworth_iir_cascade_test;
	import bic_pkg::*;

	localparam int PHASE_COUNT  = 9;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_TICKS = 25;
	localparam int SMP_MAX      = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int SMP_MIN      = -SMP_MAX - 1;
	localparam longint S32_MAX  = 64'sd2147483647;
	localparam longint S32_MIN  = -S32_MAX - 1;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_BQ0 + CFG_IDX_W'(NUM_BQ);

	typedef logic [SAMPLE_BITS-1:0] smp_t;

	typedef enum logic [3:0] {
		SU_KEEP,
		SU_PASS,
		SU_BAD_INDEX,
		SU_LP7,
		SU_HP7,
		SU_SAT,
		SU_FIRST_ONLY,
		SU_HP6_NEG
	} setup_e;

	typedef enum logic [1:0] {
		COEF_GAIN,
		COEF_FB,
		COEF_MID
	} coef_e;

	typedef struct packed {
		setup_e             setup;
		logic signed [31:0] sample;
		logic               start;
		logic               typed;
		logic signed [31:0] want;
	} row_t;

	localparam int ROW_COUNT = 23;
	localparam row_t ROWS [0:ROW_COUNT-1] = '{
		'{SU_KEEP,        8388607, 1'b0, 1'b1, 0},
		'{SU_KEEP,       -8388608, 1'b1, 1'b1, 0},
		'{SU_PASS,        8388607, 1'b0, 1'b1, 8388607},
		'{SU_KEEP,       -8388608, 1'b0, 1'b1, -8388608},
		'{SU_KEEP,              0, 1'b1, 1'b1, 0},
		'{SU_BAD_INDEX,  -1234567, 1'b0, 1'b1, -1234567},
		'{SU_LP7,         8388607, 1'b1, 1'b0, 0},
		'{SU_KEEP,        8388607, 1'b0, 1'b0, 0},
		'{SU_KEEP,       -8388608, 1'b0, 1'b0, 0},
		'{SU_KEEP,              5, 1'b0, 1'b0, 0},
		'{SU_KEEP,              0, 1'b1, 1'b0, 0},
		'{SU_HP7,         8388607, 1'b1, 1'b0, 0},
		'{SU_KEEP,       -8388608, 1'b0, 1'b0, 0},
		'{SU_KEEP,        8388607, 1'b0, 1'b0, 0},
		'{SU_SAT,         8388607, 1'b1, 1'b0, 0},
		'{SU_KEEP,       -8388608, 1'b0, 1'b0, 0},
		'{SU_KEEP,        8388607, 1'b0, 1'b0, 0},
		'{SU_FIRST_ONLY, -8388608, 1'b1, 1'b0, 0},
		'{SU_KEEP,         100000, 1'b0, 1'b0, 0},
		'{SU_HP6_NEG,     4194304, 1'b1, 1'b0, 0},
		'{SU_KEEP,       -4194304, 1'b0, 1'b0, 0},
		'{SU_KEEP,              1, 1'b0, 1'b0, 0},
		'{SU_KEEP,             -1, 1'b0, 1'b0, 0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	bic_in_if  in_ch ();
	bic_out_if out_ch ();

	butterworth_iir_cascade dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (in_ch),
		.result_ch (out_ch)
	);

	always #2 clk = ~clk;

	// filter settings and section history as the block should hold them
	logic             lp_m;
	logic [POLE_W-1:0] poles_m;
	int               mid_m;
	logic [CFG_W-1:0] first_m;
	logic [CFG_W-1:0] bq_m [NUM_BQ];
	int               fo_x1, fo_y1;
	int               bq_x1 [NUM_BQ];
	int               bq_x2 [NUM_BQ];
	int               bq_y1 [NUM_BQ];
	int               bq_y2 [NUM_BQ];

	smp_t expected_samples [$];
	smp_t oldest;
	int   items_sent = 0;
	int   results_seen = 0;
	int   mismatches = 0;
	int   trace_starts = 0;
	int   settings_used = 0;
	bit   calm = 1'b0;
	bit   hold_req = 1'b0;

	function automatic longint round_q(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic int clamp32(longint v);
		if (v > S32_MAX)
			return int'(S32_MAX);
		if (v < S32_MIN)
			return int'(S32_MIN);
		return int'(v);
	endfunction

	function automatic int gain_stage(longint s, logic [CFG_W-1:0] c);
		longint g;
		longint inner;
		g = longint'($signed(c[63:32]));
		inner = clamp32(s);
		return clamp32(round_q(inner * g, 30));
	endfunction

	function automatic void clear_history();
		fo_x1 = 0;
		fo_y1 = 0;
		for (int j = 0; j < NUM_BQ; j++) begin
			bq_x1[j] = 0;
			bq_x2[j] = 0;
			bq_y1[j] = 0;
			bq_y2[j] = 0;
		end
	endfunction

	function automatic smp_t cascade_step(smp_t smp, logic start);
		int     v;
		int     nbq;
		longint s;
		v = $signed(smp);
		if (start)
			clear_history();
		if (poles_m[0]) begin
			s = lp_m ? longint'(v) + fo_x1 : longint'(v) - fo_x1;
			s -= round_q(longint'($signed(first_m[31:0])) * fo_y1, 16);
			fo_x1 = v;
			v = gain_stage(s, first_m);
			fo_y1 = v;
		end
		nbq = int'(poles_m) / 2;
		if (nbq > MAX_POLES / 2)
			nbq = MAX_POLES / 2;
		if (nbq > NUM_BQ)
			nbq = NUM_BQ;
		for (int j = 0; j < nbq; j++) begin
			s = lp_m ? longint'(v) + 2 * longint'(bq_x1[j]) : longint'(v) - 2 * longint'(bq_x1[j]);
			s += bq_x2[j];
			s -= round_q(longint'(mid_m) * bq_y1[j], 16);
			s -= round_q(longint'($signed(bq_m[j][31:0])) * bq_y2[j], 16);
			bq_x2[j] = bq_x1[j];
			bq_x1[j] = v;
			v = gain_stage(s, bq_m[j]);
			bq_y2[j] = bq_y1[j];
			bq_y1[j] = v;
		end
		if (v > SMP_MAX)
			v = SMP_MAX;
		if (v < SMP_MIN)
			v = SMP_MIN;
		return smp_t'(v);
	endfunction

	function automatic void store_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_LOWPASS: lp_m = data[0];
			REG_POLES: poles_m = data[POLE_W-1:0];
			REG_MID: mid_m = data[31:0];
			REG_FIRST: first_m = data;
			default: begin
				if (idx >= REG_BQ0 && idx < REG_UNUSED)
					bq_m[idx - REG_BQ0] = data;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_coeff(bit wild, coef_e kind);
		logic [31:0] c;
		if (wild) begin
			case ($urandom_range(0, 3))
				0: c = 32'h7fffffff;
				1: c = 32'h80000000;
				2: c = 32'h0;
				default: c = $urandom;
			endcase
			return c;
		end
		case (kind)
			COEF_GAIN: c = $urandom_range(32'h40000000, 32'h04000000);
			COEF_FB: c = $urandom_range(0, 32'h30000);
			default: c = $urandom_range(0, 32'h28000);
		endcase
		if ($urandom_range(0, 7) == 0 || (kind != COEF_GAIN && $urandom_range(0, 1) == 0))
			c = -c;
		return c;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		store_setting(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic apply_setup(setup_e su);
		case (su)
			SU_PASS: write_reg(REG_POLES, {61'($urandom), 3'd0});
			SU_BAD_INDEX: write_reg(REG_UNUSED, {$urandom, $urandom});
			SU_LP7, SU_HP7: begin
				write_reg(REG_LOWPASS, (su == SU_LP7) ? 64'd1 : 64'd0);
				write_reg(REG_POLES, 64'd7);
				write_reg(REG_MID, {32'h0, 32'hfffe8000});
				write_reg(REG_FIRST, {32'h20000000, 32'hffff8000});
				write_reg(REG_BQ0, {32'h10000000, 32'h00009000});
				write_reg(REG_BQ0 + 3'd1, {32'h30000000, 32'h0000c000});
				write_reg(REG_BQ0 + 3'd2, {32'h40000000, 32'h00004000});
			end
			SU_SAT: begin
				write_reg(REG_LOWPASS, 64'd1);
				write_reg(REG_POLES, 64'd7);
				write_reg(REG_MID, {32'hffffffff, 32'h80000000});
				write_reg(REG_FIRST, {32'h7fffffff, 32'h7fffffff});
				write_reg(REG_BQ0, {32'h80000000, 32'h80000000});
				write_reg(REG_BQ0 + 3'd1, {32'h7fffffff, 32'h80000000});
				write_reg(REG_BQ0 + 3'd2, {32'h80000000, 32'h7fffffff});
			end
			SU_FIRST_ONLY: begin
				write_reg(REG_LOWPASS, 64'd0);
				write_reg(REG_POLES, 64'd1);
				write_reg(REG_FIRST, {32'h40000000, 32'h00010000});
			end
			SU_HP6_NEG: begin
				write_reg(REG_POLES, 64'd6);
				write_reg(REG_MID, {32'h0, 32'h7fffffff});
				write_reg(REG_BQ0, {32'hc0000000, 32'hffff0000});
				write_reg(REG_BQ0 + 3'd1, {32'hf0000000, 32'h00020000});
				write_reg(REG_BQ0 + 3'd2, {32'h80000000, 32'h00000000});
			end
			default: ;
		endcase
	endtask

	task automatic shuffle_config(int phase);
		bit                wild;
		logic [POLE_W-1:0] p;
		wild = (phase == 0) || (phase == PHASE_COUNT - 1) || ($urandom_range(0, 3) == 0);
		if (phase == 0)
			p = 3'd7;
		else if (phase == 1)
			p = 3'd0;
		else
			p = 3'($urandom_range(0, 7));
		write_reg(REG_LOWPASS, {$urandom, $urandom});
		write_reg(REG_POLES, {61'({$urandom, $urandom}), p});
		write_reg(REG_MID, {$urandom, pick_coeff(wild, COEF_MID)});
		write_reg(REG_FIRST, {pick_coeff(wild, COEF_GAIN), pick_coeff(wild, COEF_FB)});
		for (int j = 0; j < NUM_BQ; j++)
			write_reg(REG_BQ0 + CFG_IDX_W'(j), {pick_coeff(wild, COEF_GAIN), pick_coeff(wild, COEF_FB)});
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNUSED, {$urandom, $urandom});
		settings_used++;
	endtask

	task automatic offer(smp_t smp, logic start, logic typed, smp_t want);
		int   gap;
		smp_t got;
		gap = 0;
		if (!calm && !hold_req && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.sample_in = smp;
		in_ch.trace_start = start;
		do
			@(posedge clk);
		while (!in_ch.ready);
		got = cascade_step(smp, start);
		expected_samples.push_back(typed ? want : got);
		items_sent++;
		if (start)
			trace_starts++;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		in_ch.trace_start = 1'b0;
		lp_m = 1'b1;
		poles_m = 3'd2;
		mid_m = 0;
		first_m = '0;
		for (int j = 0; j < NUM_BQ; j++)
			bq_m[j] = '0;
		clear_history();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < ROW_COUNT; r++) begin
			if (ROWS[r].setup != SU_KEEP) begin
				settle();
				apply_setup(ROWS[r].setup);
			end
			offer(smp_t'(ROWS[r].sample), ROWS[r].start, ROWS[r].typed, smp_t'(ROWS[r].want));
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			settle();
			shuffle_config(ph);
			calm = (ph == 2);
			if (ph == 3)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				smp_t s;
				case ($urandom_range(0, 9))
					0: begin
						case ($urandom_range(0, 3))
							0: s = smp_t'(SMP_MAX);
							1: s = smp_t'(SMP_MIN);
							2: s = '0;
							default: s = '1;
						endcase
					end
					1, 2: s = smp_t'(int'($urandom_range(0, 2000)) - 1000);
					default: s = smp_t'($urandom);
				endcase
				offer(s, $urandom_range(0, 39) == 0, 1'b0, '0);
			end
			calm = 1'b0;
		end

		settle();
		$display("drove %0d samples (%0d trace starts) through %0d directed rows and %0d random settings",
			items_sent, trace_starts, ROW_COUNT, settings_used);
		$display("checked %0d results, %0d bad, with one long output hold-off", results_seen, mismatches);
		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin : drain
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else begin
				out_ch.ready = 1'b1;
				if (!calm && $urandom_range(0, 4) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: sample_out %0d with nothing outstanding",
						results_seen, $signed(out_ch.sample_out));
			end else begin
				oldest = expected_samples.pop_front();
				if (out_ch.sample_out !== oldest) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: sample_out expected %0d, got %0d",
							results_seen, $signed(oldest), $signed(out_ch.sample_out));
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no item moved for %0d cycles", IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule

### butterworth_iir_cascade.f
src/bic_pkg.sv
src/bic_ifs.sv
src/bic_cfg.sv
src/bic_ctrl.sv
src/bic_dp.sv
src/butterworth_iir_cascade.sv
tb/butterworth_iir_cascade_test.sv
